>>> hdl/sfdc_pkg.sv
// ----------------------------------------------------------------------------
// sfdc_pkg
// shared types and constants of the sensor frame deframer
// ----------------------------------------------------------------------------
package sfdc_pkg;

  // stream widths
  localparam int BYTE_W   = 8;
  localparam int TDATA_W  = 40;   // payload word (32) + word index (5), padded
  localparam int TUSER_W  = 4;    // result kind (3) + attitude flag (1)
  localparam int WORD_W   = 32;
  localparam int WIDX_W   = 5;
  localparam int LEN_W    = 7;
  localparam int CRC_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_TYPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_TYPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_TYPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_LEN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC8_POLY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC16_POLY  = 3'd7;

  // result kinds
  typedef enum logic [2:0] {
    KIND_WORD     = 3'd0,
    KIND_BAD_TYPE = 3'd1,
    KIND_HDR_CRC  = 3'd2,
    KIND_PAY_CRC  = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC_RD,
    ST_CRC_OP,
    ST_CRC_CHK,
    ST_WORD_RD,
    ST_WORD_ACC,
    ST_EMIT
  } state_t;

  // control of the shared crc unit
  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctrl_t;

endpackage

>>> hdl/sfdc_crc_unit.sv
// ----------------------------------------------------------------------------
// sfdc_crc_unit
// shared msb-first crc shift unit, one byte per step, 16-bit register
// ----------------------------------------------------------------------------
module sfdc_crc_unit (
  input  logic                      clk,
  input  sfdc_pkg::crc_ctrl_t       ctrl,
  input  logic [sfdc_pkg::BYTE_W-1:0] data_byte,
  input  logic [sfdc_pkg::CRC_W-1:0]  poly,
  output logic [sfdc_pkg::CRC_W-1:0]  crc
);
  import sfdc_pkg::*;

  // crc-8 runs in the upper byte with the polynomial shifted up by eight
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d,
                                                input logic [CRC_W-1:0] p);
    logic [CRC_W-1:0] c;
    c = c_in ^ {d, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) c = {c[CRC_W-2:0], 1'b0} ^ p;
      else            c = {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc <= '0;
    end else if (ctrl.step) begin
      crc <= crc_byte(crc, data_byte, poly);
    end
  end

endmodule

>>> hdl/sensor_frame_deframer_crc_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer_crc_top
// byte stream deframer with header crc-8 and payload crc-16 checks
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | tdata[7:0] rx_byte
//  m_axis    | out       | tdata payload_word/word_index, tuser kind/attitude,
//            |           | tlast last_word
//  cfg       | in        | cfg_wr_en, cfg_index[2:0], cfg_data[15:0]
//
// a byte that causes no check keeps the sequencer idle; s_axis_tready is low
// while the sequencer works. the header check at byte five walks bytes 0..3
// through the shared crc unit in read and step states, then checks; the payload
// check at byte L-1 does likewise; a good frame then reads its payload from
// the frame store in read and accumulate states, with an emit state per word
// that waits for m_axis. the last result waits in the output register while
// the next byte is taken. reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_crc_top #(
  parameter int MAX_FRAME = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sfdc_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sfdc_pkg::TDATA_W-1:0]      m_axis_tdata,   // [31:0] payload_word,
                                                            // [36:32] word_index
  output logic [sfdc_pkg::TUSER_W-1:0]      m_axis_tuser,   // [2:0] result_kind,
                                                            // [3] is_attitude
  output logic                              m_axis_tlast,   // last_word
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [sfdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfdc_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = 9;                            // compare width for positions
  localparam logic [CW-1:0] POS_LIMIT = CW'(MAX_FRAME - 1);

  // configuration registers
  logic [15:0]       marker;
  logic [7:0]        motion_code;
  logic [7:0]        att_code;
  logic [7:0]        ign_code;
  logic [LEN_W-1:0]  motion_len;
  logic [LEN_W-1:0]  att_len;
  logic [7:0]        crc8_poly;
  logic [15:0]       crc16_poly;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker      <= 16'hFDDC;
      motion_code <= 8'h40;
      att_code    <= 8'h41;
      ign_code    <= 8'hFF;
      motion_len  <= 7'd64;
      att_len     <= 7'd56;
      crc8_poly   <= 8'h07;
      crc16_poly  <= 16'h1021;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MARKER:      marker      <= cfg_data;
        CFG_MOTION_TYPE: motion_code <= cfg_data[7:0];
        CFG_ATT_TYPE:    att_code    <= cfg_data[7:0];
        CFG_IGN_TYPE:    ign_code    <= cfg_data[7:0];
        CFG_MOTION_LEN:  motion_len  <= cfg_data[LEN_W-1:0];
        CFG_ATT_LEN:     att_len     <= cfg_data[LEN_W-1:0];
        CFG_CRC8_POLY:   crc8_poly   <= cfg_data[7:0];
        CFG_CRC16_POLY:  crc16_poly  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [7:0] head_byte;
  logic [7:0] end_byte;
  assign head_byte = marker[7:0];
  assign end_byte  = marker[15:8];

  // control state
  state_t            state, state_next;
  logic              in_frame, in_frame_next;
  logic [AW-1:0]     pos, pos_next;
  logic [LEN_W-1:0]  exp_len, exp_len_next;
  logic [7:0]        prev, prev_next;
  logic              out_valid, out_valid_next;

  // working registers
  logic [7:0]        typ, typ_next;            // frame type byte
  logic [7:0]        cmp_byte, cmp_byte_next;  // received header crc
  logic [15:0]       rx_crc, rx_crc_next;      // received payload crc
  logic              crc_hdr, crc_hdr_next;    // header pass, else payload
  logic [LEN_W-1:0]  cnt, cnt_next;            // byte counter of a pass
  logic [LEN_W-1:0]  run_len, run_len_next;    // bytes in the pass
  logic [WIDX_W-1:0] words, words_next;
  logic              att, att_next;
  logic [WORD_W-1:0] acc, acc_next;
  kind_t             pend_kind, pend_kind_next;

  // output register
  kind_t             out_kind, out_kind_next;
  logic              out_att, out_att_next;
  logic [WORD_W-1:0] out_word, out_word_next;
  logic [WIDX_W-1:0] out_idx, out_idx_next;
  logic              out_last, out_last_next;

  // frame store
  logic [7:0]    frame_store [MAX_FRAME];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= s_axis_tdata;
    end
    rd_data <= frame_store[rd_addr];
  end

  // header bytes start at zero, payload bytes at seven
  logic [CW-1:0] addr_sum;
  assign addr_sum = CW'(cnt) + (crc_hdr ? CW'(0) : CW'(7));
  assign rd_addr  = addr_sum[AW-1:0];

  // shared crc unit
  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc_poly;
  logic [15:0] crc_val;

  assign crc_poly = crc_hdr ? {crc8_poly, 8'h00} : crc16_poly;

  sfdc_crc_unit u_crc (
    .clk       (clk),
    .ctrl      (crc_ctrl),
    .data_byte (rd_data),
    .poly      (crc_poly),
    .crc       (crc_val)
  );

  // handy values of the accepted byte
  logic [7:0]       b;
  logic             accept;
  logic [CW-1:0]    posn;
  logic [CW-1:0]    exp9;
  logic             known;
  logic [LEN_W-1:0] plen;
  logic [7:0]       wsum;
  logic             out_free;
  logic             word_last;

  assign b         = s_axis_tdata;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign posn      = CW'(pos) + CW'(1);
  assign exp9      = CW'(exp_len);
  assign known     = (typ == motion_code) || (typ == att_code);
  assign plen      = exp_len - LEN_W'(8);
  assign wsum      = 8'(plen) + 8'd3;
  assign out_free  = !out_valid || m_axis_tready;
  assign word_last = (cnt[LEN_W-1:2] == words - WIDX_W'(1));

  function automatic logic [LEN_W-1:0] latch_len(input logic [LEN_W-1:0] len);
    return (len < LEN_W'(8)) ? LEN_W'(8) : len;
  endfunction

  always_comb begin
    state_next     = state;
    in_frame_next  = in_frame;
    pos_next       = pos;
    exp_len_next   = exp_len;
    prev_next      = prev;
    out_valid_next = out_valid && !m_axis_tready;
    typ_next       = typ;
    cmp_byte_next  = cmp_byte;
    rx_crc_next    = rx_crc;
    crc_hdr_next   = crc_hdr;
    cnt_next       = cnt;
    run_len_next   = run_len;
    words_next     = words;
    att_next       = att;
    acc_next       = acc;
    pend_kind_next = pend_kind;
    out_kind_next  = out_kind;
    out_att_next   = out_att;
    out_word_next  = out_word;
    out_idx_next   = out_idx;
    out_last_next  = out_last;
    wr_en          = 1'b0;
    wr_addr        = pos;
    crc_ctrl       = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          prev_next = b;
          if (prev == end_byte && b == head_byte) begin
            // frame start, also restarts a frame under way
            wr_en         = 1'b1;
            wr_addr       = '0;
            pos_next      = AW'(1);
            in_frame_next = 1'b1;
          end else if (in_frame && CW'(pos) < POS_LIMIT) begin
            wr_en    = 1'b1;
            pos_next = posn[AW-1:0];
            if (posn == CW'(6)) rx_crc_next[15:8] = b;
            if (posn == CW'(7)) rx_crc_next[7:0]  = b;
            if (posn == CW'(2)) begin
              // type byte
              typ_next = b;
              if (b == motion_code) begin
                exp_len_next = latch_len(motion_len);
              end else if (b == att_code) begin
                exp_len_next = latch_len(att_len);
              end else if (b == ign_code) begin
                in_frame_next = 1'b0;
                pos_next      = '0;
              end else begin
                in_frame_next  = 1'b0;
                pos_next       = '0;
                pend_kind_next = KIND_BAD_TYPE;
                state_next     = ST_EMIT;
              end
            end else if (posn == CW'(5)) begin
              // header crc over bytes 0..3 against this byte
              cmp_byte_next  = b;
              crc_hdr_next   = 1'b1;
              run_len_next   = LEN_W'(4);
              cnt_next       = '0;
              crc_ctrl.clear = 1'b1;
              state_next     = ST_CRC_RD;
            end else if (exp_len != '0 && posn + CW'(1) == exp9) begin
              // payload crc, empty payload checks straight away
              crc_hdr_next   = 1'b0;
              run_len_next   = plen;
              cnt_next       = '0;
              crc_ctrl.clear = 1'b1;
              state_next     = (plen == '0) ? ST_CRC_CHK : ST_CRC_RD;
            end else if (exp_len != '0 && posn >= exp9) begin
              // end byte
              in_frame_next = 1'b0;
              pos_next      = '0;
              exp_len_next  = '0;
              if (b == end_byte) begin
                if (known && plen != '0) begin
                  crc_hdr_next   = 1'b0;
                  run_len_next   = plen;
                  cnt_next       = '0;
                  words_next     = wsum[WIDX_W+1:2];
                  att_next       = (typ != motion_code);
                  pend_kind_next = KIND_WORD;
                  state_next     = ST_WORD_RD;
                end
              end else begin
                pend_kind_next = KIND_END;
                state_next     = ST_EMIT;
              end
            end
          end
        end
      end

      ST_CRC_RD: begin
        state_next = ST_CRC_OP;
      end

      ST_CRC_OP: begin
        crc_ctrl.step = 1'b1;
        if (cnt + LEN_W'(1) == run_len) begin
          state_next = ST_CRC_CHK;
        end else begin
          cnt_next   = cnt + LEN_W'(1);
          state_next = ST_CRC_RD;
        end
      end

      ST_CRC_CHK: begin
        if (crc_hdr ? (crc_val[15:8] != cmp_byte) : (crc_val != rx_crc)) begin
          in_frame_next  = 1'b0;
          pos_next       = '0;
          pend_kind_next = crc_hdr ? KIND_HDR_CRC : KIND_PAY_CRC;
          state_next     = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_WORD_RD: begin
        state_next = ST_WORD_ACC;
      end

      ST_WORD_ACC: begin
        // bytes past the payload pad the last word with zeros
        for (int k = 0; k < 4; k++) begin
          if (cnt[1:0] == 2'(k)) begin
            acc_next[8*k +: 8] = (cnt < run_len) ? rd_data : 8'h00;
          end
        end
        if (cnt[1:0] == 2'd3) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next   = cnt + LEN_W'(1);
          state_next = ST_WORD_RD;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = pend_kind;
          if (pend_kind == KIND_WORD) begin
            out_att_next  = att;
            out_word_next = acc;
            out_idx_next  = cnt[LEN_W-1:2];
            out_last_next = word_last;
            if (word_last) begin
              state_next = ST_IDLE;
            end else begin
              cnt_next   = cnt + LEN_W'(1);
              state_next = ST_WORD_RD;
            end
          end else begin
            out_att_next  = 1'b0;
            out_word_next = '0;
            out_idx_next  = '0;
            out_last_next = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_frame  <= 1'b0;
      pos       <= '0;
      exp_len   <= '0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_frame  <= in_frame_next;
      pos       <= pos_next;
      exp_len   <= exp_len_next;
      prev      <= prev_next;
      out_valid <= out_valid_next;
    end
  end

  // working and output registers
  always_ff @(posedge clk) begin
    typ       <= typ_next;
    cmp_byte  <= cmp_byte_next;
    rx_crc    <= rx_crc_next;
    crc_hdr   <= crc_hdr_next;
    cnt       <= cnt_next;
    run_len   <= run_len_next;
    words     <= words_next;
    att       <= att_next;
    acc       <= acc_next;
    pend_kind <= pend_kind_next;
    out_kind  <= out_kind_next;
    out_att   <= out_att_next;
    out_word  <= out_word_next;
    out_idx   <= out_idx_next;
    out_last  <= out_last_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_idx, out_word};
  assign m_axis_tuser  = {out_att, out_kind};
  assign m_axis_tlast  = out_last;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sensor frame deframer: a byte queue feeds the
// slave stream, a local deframer model predicts every result item, and the
// master stream is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfdc_pkg::*;

  localparam int  MAX_FRAME    = 128;
  localparam int  HALF_PERIOD  = 5;
  localparam int  RESET_CYCLES = 9;
  localparam int  CYCLE_LIMIT  = 1000000;
  // longest silent job: payload check plus payload read of a 127 byte frame
  localparam int  SETTLE       = 1000;
  localparam int  DRAIN_LIMIT  = 200000;

  // frame shapes the stimulus builder knows
  typedef enum int {
    SHAPE_GOOD_MOTION,
    SHAPE_GOOD_ATT,
    SHAPE_BAD_TYPE,
    SHAPE_IGNORED,
    SHAPE_HDR_CRC,
    SHAPE_PAY_CRC,
    SHAPE_END_BAD,
    SHAPE_RESTART
  } frame_shape_t;

  // type codes rewritten halfway through a frame
  typedef enum int {
    RETYPE_NONE,
    RETYPE_TO_ATT,
    RETYPE_TO_UNKNOWN
  } retype_t;

  typedef struct packed {
    kind_t       kind;
    logic        attitude;
    logic [31:0] word;
    logic [4:0]  widx;
    logic        last;
  } frame_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [TDATA_W-1:0]     m_axis_tdata;   // [31:0] payload_word, [36:32] word_index
  logic [TUSER_W-1:0]     m_axis_tuser;   // [2:0] result_kind, [3] is_attitude
  logic                   m_axis_tlast;   // last_word

  // bytes still to go onto the link, and results the deframer owes us
  logic [7:0]     link_bytes [$];
  frame_result_t  expected_results [$];

  // mirror of the register file
  logic [15:0] cfg_marker      = 16'hFDDC;
  logic [7:0]  cfg_motion_type = 8'h40;
  logic [7:0]  cfg_att_type    = 8'h41;
  logic [7:0]  cfg_ign_type    = 8'hFF;
  logic [6:0]  cfg_motion_len  = 7'd64;
  logic [6:0]  cfg_att_len     = 7'd56;
  logic [7:0]  cfg_crc8_poly   = 8'h07;
  logic [15:0] cfg_crc16_poly  = 16'h1021;

  // deframer model state
  logic [7:0]  frame_bytes [MAX_FRAME];
  int          fpos     = 0;
  int          want_len = 0;
  bit          framing  = 1'b0;
  logic [7:0]  prev_rx  = 8'h00;

  // bench bookkeeping
  logic [7:0]  last_queued  = 8'h00;
  bit          steady       = 1'b0;   // no idling on either side while set
  int          framed_bytes = 0;
  int          mismatches   = 0;
  int          cycles       = 0;
  int          tx_gap       = 0;
  int          rx_stall     = 0;

  sensor_frame_deframer_crc_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ------------------------------------------------------------------------
  // crc helpers, msb first, one byte per call
  // ------------------------------------------------------------------------
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ d;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    return c;
  endfunction

  // lengths under eight are taken as eight when latched
  function automatic int clamp_len(input logic [6:0] len);
    return (len < 7'd8) ? 8 : int'(len);
  endfunction

  // motion wins over attitude when the codes are equal
  function automatic int len_for_type(input logic [7:0] ftype);
    return (ftype == cfg_motion_type) ? clamp_len(cfg_motion_len) : clamp_len(cfg_att_len);
  endfunction

  // ------------------------------------------------------------------------
  // deframer model
  // ------------------------------------------------------------------------
  function automatic void push_result(input kind_t k, input logic att, input logic [31:0] w,
                                      input logic [4:0] idx, input logic lst);
    frame_result_t r;
    r.kind     = k;
    r.attitude = att;
    r.word     = w;
    r.widx     = idx;
    r.last     = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void drop_frame();
    framing = 1'b0;
    fpos    = 0;
  endfunction

  function automatic void deframe_step(input logic [7:0] rx);
    logic [7:0]  head_mark;
    logic [7:0]  end_mark;
    logic [7:0]  ftype;
    logic [7:0]  c8;
    logic [15:0] c16;
    logic [31:0] word;
    int          plen;
    int          nwords;
    int          p;
    head_mark = cfg_marker[7:0];
    end_mark  = cfg_marker[15:8];
    if (prev_rx == end_mark && rx == head_mark) begin
      // head right after end opens a frame, even over one under way
      frame_bytes[0] = rx;
      fpos           = 1;
      framing        = 1'b1;
    end else if (framing && fpos < MAX_FRAME - 1) begin
      frame_bytes[fpos] = rx;
      fpos++;
      if (fpos == 2) begin
        ftype = frame_bytes[1];
        if (ftype == cfg_motion_type) begin
          want_len = clamp_len(cfg_motion_len);
        end else if (ftype == cfg_att_type) begin
          want_len = clamp_len(cfg_att_len);
        end else if (ftype == cfg_ign_type) begin
          drop_frame();
        end else begin
          drop_frame();
          push_result(KIND_BAD_TYPE, 1'b0, '0, '0, 1'b1);
        end
      end
      if (fpos == 5) begin
        c8 = 8'h00;
        for (int i = 0; i < 4; i++) c8 = crc8_step(c8, frame_bytes[i], cfg_crc8_poly);
        if (c8 != frame_bytes[4]) begin
          drop_frame();
          push_result(KIND_HDR_CRC, 1'b0, '0, '0, 1'b1);
        end
      end
      if (want_len > 0 && fpos == want_len - 1) begin
        c16 = 16'h0000;
        for (int i = 0; i < want_len - 8; i++)
          c16 = crc16_step(c16, frame_bytes[7 + i], cfg_crc16_poly);
        if (c16 != {frame_bytes[5], frame_bytes[6]}) begin
          drop_frame();
          push_result(KIND_PAY_CRC, 1'b0, '0, '0, 1'b1);
        end
      end
      if (want_len > 0 && fpos >= want_len) begin
        if (frame_bytes[fpos - 1] == end_mark) begin
          // type is matched against the codes in force now
          ftype = frame_bytes[1];
          if (ftype == cfg_motion_type || ftype == cfg_att_type) begin
            plen   = want_len - 8;
            nwords = (plen + 3) / 4;
            for (int w = 0; w < nwords; w++) begin
              word = '0;
              for (int j = 0; j < 4; j++) begin
                p = w * 4 + j;
                if (p < plen) word[8*j +: 8] = frame_bytes[7 + p];
              end
              push_result(KIND_WORD, ftype != cfg_motion_type, word, 5'(w), w + 1 == nwords);
            end
          end
        end else begin
          push_result(KIND_END, 1'b0, '0, '0, 1'b1);
        end
        drop_frame();
        want_len = 0;
      end
    end
    prev_rx = rx;
  endfunction

  // ------------------------------------------------------------------------
  // idling: mostly short gaps, a few long ones, none in steady stretches
  // ------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ------------------------------------------------------------------------
  // slave side driver, fed from the byte queue
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : drive_link
    bit fire;
    if (!rst) begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) deframe_step(s_axis_tdata);
      if (fire || !s_axis_tvalid) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          s_axis_tdata  <= link_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // master side monitor and checker
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    frame_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: kind %0d word %0h",
                 m_axis_tuser[2:0], m_axis_tdata[31:0]);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind",  want.kind,     m_axis_tuser[2:0]);
          check_field("is_attitude",  want.attitude, m_axis_tuser[3]);
          check_field("payload_word", want.word,     m_axis_tdata[31:0]);
          check_field("word_index",   want.widx,     m_axis_tdata[36:32]);
          check_field("last_word",    want.last,     m_axis_tlast);
        end
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sensor_frame_deframer_crc_top");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] v, input bit counted);
    link_bytes.push_back(v);
    last_queued = v;
    if (counted) framed_bytes++;
  endfunction

  // random content that never forms an end-then-head pair by accident
  function automatic logic [7:0] pick_content(input logic [7:0] prior);
    logic [7:0] v;
    v = 8'($urandom);
    if (prior == cfg_marker[15:8] && v == cfg_marker[7:0]) v = ~v;
    return v;
  endfunction

  // wait until the link is empty and every result is in, then let the
  // sequencer finish any job that owes no result
  task automatic wait_drained();
    int spin;
    spin = 0;
    @(negedge clk);
    while ((link_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
           && spin < DRAIN_LIMIT) begin
      @(negedge clk);
      spin++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void mirror_write(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      CFG_MARKER:      cfg_marker      = val;
      CFG_MOTION_TYPE: cfg_motion_type = val[7:0];
      CFG_ATT_TYPE:    cfg_att_type    = val[7:0];
      CFG_IGN_TYPE:    cfg_ign_type    = val[7:0];
      CFG_MOTION_LEN:  cfg_motion_len  = val[6:0];
      CFG_ATT_LEN:     cfg_att_len     = val[6:0];
      CFG_CRC8_POLY:   cfg_crc8_poly   = val[7:0];
      CFG_CRC16_POLY:  cfg_crc16_poly  = val;
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    mirror_write(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // queue one frame of the given shape; optionally pause partway through,
  // let the block go idle and rewrite the type codes
  task automatic queue_frame(input frame_shape_t shape, input int retype_at,
                             input retype_t retype_mode);
    logic [7:0]  fb [MAX_FRAME];
    logic [7:0]  ftype;
    logic [7:0]  old_type;
    logic [15:0] c16;
    int          flen;
    int          count;
    case (shape)
      SHAPE_BAD_TYPE: begin
        ftype = 8'($urandom);
        while (ftype == cfg_motion_type || ftype == cfg_att_type || ftype == cfg_ign_type)
          ftype = 8'($urandom);
      end
      SHAPE_IGNORED:     ftype = cfg_ign_type;
      SHAPE_GOOD_MOTION: ftype = cfg_motion_type;
      SHAPE_GOOD_ATT:    ftype = cfg_att_type;
      default:           ftype = $urandom_range(0, 1) ? cfg_motion_type : cfg_att_type;
    endcase
    if (shape == SHAPE_BAD_TYPE || shape == SHAPE_IGNORED) flen = $urandom_range(2, 5);
    else flen = len_for_type(ftype);
    fb[0] = cfg_marker[7:0];
    fb[1] = ftype;
    for (int i = 2; i < flen; i++) fb[i] = pick_content(fb[i - 1]);
    if (flen >= 8) begin
      fb[4] = 8'h00;
      for (int i = 0; i < 4; i++) fb[4] = crc8_step(fb[4], fb[i], cfg_crc8_poly);
      c16 = 16'h0000;
      for (int i = 7; i < flen - 1; i++) c16 = crc16_step(c16, fb[i], cfg_crc16_poly);
      fb[5]        = c16[15:8];
      fb[6]        = c16[7:0];
      fb[flen - 1] = cfg_marker[15:8];
    end
    count = flen;
    case (shape)
      SHAPE_HDR_CRC: fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
      SHAPE_PAY_CRC: begin
        if ($urandom_range(0, 1)) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
        else fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
      end
      SHAPE_END_BAD: fb[flen - 1] = fb[flen - 1] ^ 8'($urandom_range(1, 255));
      SHAPE_RESTART: count = $urandom_range(1, flen - 2);
      default: ;
    endcase
    // a frame only opens when the head follows an end byte
    if (last_queued != cfg_marker[15:8]) push_byte(cfg_marker[15:8], 1'b1);
    for (int i = 0; i < count; i++) begin
      if (retype_mode != RETYPE_NONE && i == retype_at) begin
        wait_drained();
        old_type = cfg_motion_type;
        write_reg(CFG_MOTION_TYPE, {8'h00, old_type ^ 8'h5A});
        if (retype_mode == RETYPE_TO_ATT) write_reg(CFG_ATT_TYPE, {8'h00, old_type});
        else write_reg(CFG_ATT_TYPE, {8'h00, old_type ^ 8'hA5});
      end
      push_byte(fb[i], 1'b1);
    end
  endtask

  task automatic queue_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      queue_frame(SHAPE_GOOD_MOTION, 0, RETYPE_NONE);
    else if (r < 55) queue_frame(SHAPE_GOOD_ATT, 0, RETYPE_NONE);
    else if (r < 62) queue_frame(SHAPE_BAD_TYPE, 0, RETYPE_NONE);
    else if (r < 67) queue_frame(SHAPE_IGNORED, 0, RETYPE_NONE);
    else if (r < 74) queue_frame(SHAPE_HDR_CRC, 0, RETYPE_NONE);
    else if (r < 81) queue_frame(SHAPE_PAY_CRC, 0, RETYPE_NONE);
    else if (r < 88) queue_frame(SHAPE_END_BAD, 0, RETYPE_NONE);
    else if (r < 94) queue_frame(SHAPE_RESTART, 0, RETYPE_NONE);
    else repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
  endtask

  // mostly short frames, a few under eight and a few long ones
  function automatic logic [6:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(8, 20));
    if (r < 85) return 7'($urandom_range(0, 7));
    return 7'($urandom_range(21, 127));
  endfunction

  // new setting for every register; the first two phases pin the extremes
  task automatic roll_config(input int phase);
    logic [15:0] mk;
    logic [15:0] p16;
    logic [7:0]  mt;
    logic [7:0]  at;
    logic [7:0]  it;
    logic [7:0]  p8;
    logic [6:0]  ml;
    logic [6:0]  al;
    mk  = 16'($urandom);
    if ($urandom_range(0, 19) == 0) mk[15:8] = mk[7:0];
    mt  = 8'($urandom);
    at  = ($urandom_range(0, 6) == 0) ? mt : 8'($urandom);
    it  = ($urandom_range(0, 9) == 0) ? mt : 8'($urandom);
    ml  = pick_len();
    al  = pick_len();
    p8  = 8'($urandom);
    p16 = 16'($urandom);
    case ($urandom_range(0, 9))
      0: begin p8 = 8'h00; p16 = 16'h0000; end
      1: begin p8 = 8'hFF; p16 = 16'hFFFF; end
      default: ;
    endcase
    if (phase == 0) begin
      mk = 16'hFF00; mt = 8'h00; at = 8'hFF; it = 8'h7E;
      ml = 7'd127;   al = 7'd0;  p8 = 8'hFF; p16 = 16'hFFFF;
    end else if (phase == 1) begin
      mk = 16'h00FF; ml = 7'd8; al = 7'd127; p8 = 8'h00; p16 = 16'h0000;
    end
    // spare upper bits of the narrow registers carry noise
    write_reg(CFG_MARKER,      mk);
    write_reg(CFG_MOTION_TYPE, {8'($urandom), mt});
    write_reg(CFG_ATT_TYPE,    {8'($urandom), at});
    write_reg(CFG_IGN_TYPE,    {8'($urandom), it});
    write_reg(CFG_MOTION_LEN,  {9'($urandom), ml});
    write_reg(CFG_ATT_LEN,     {9'($urandom), al});
    write_reg(CFG_CRC8_POLY,   {8'($urandom), p8});
    write_reg(CFG_CRC16_POLY,  p16);
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    int phase;
    int base_bytes;
    for (int i = 0; i < MAX_FRAME; i++) frame_bytes[i] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: short frames, one full word, empty payload
    write_reg(CFG_MOTION_LEN, 16'd12);
    write_reg(CFG_ATT_LEN, 16'd5);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    queue_frame(SHAPE_GOOD_MOTION, 0, RETYPE_NONE);
    queue_frame(SHAPE_GOOD_ATT, 0, RETYPE_NONE);
    queue_frame(SHAPE_BAD_TYPE, 0, RETYPE_NONE);
    queue_frame(SHAPE_IGNORED, 0, RETYPE_NONE);
    queue_frame(SHAPE_HDR_CRC, 0, RETYPE_NONE);
    queue_frame(SHAPE_PAY_CRC, 0, RETYPE_NONE);
    queue_frame(SHAPE_END_BAD, 0, RETYPE_NONE);
    queue_frame(SHAPE_RESTART, 0, RETYPE_NONE);
    queue_frame(SHAPE_GOOD_MOTION, 0, RETYPE_NONE);
    // sender holds off until every result is back
    wait_drained();

    // equal type codes: the motion type takes the frame
    write_reg(CFG_ATT_TYPE, {8'h00, cfg_motion_type});
    queue_frame(SHAPE_GOOD_ATT, 0, RETYPE_NONE);
    wait_drained();
    write_reg(CFG_ATT_TYPE, 16'h0041);

    // type codes rewritten mid-frame: once to attitude, once to neither
    queue_frame(SHAPE_GOOD_MOTION, 9, RETYPE_TO_ATT);
    queue_frame(SHAPE_GOOD_MOTION, 9, RETYPE_TO_UNKNOWN);
    wait_drained();

    // random phases, each with a fresh setting; some without any idling
    phase = 0;
    while (framed_bytes < 500 && phase < 30) begin
      steady = (phase % 4 == 2);
      roll_config(phase);
      base_bytes = framed_bytes;
      while (framed_bytes - base_bytes < 90) queue_random_item();
      wait_drained();
      phase++;
    end

    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    if (mismatches == 0) $display("PASS sensor_frame_deframer_crc_top");
    else $display("FAIL sensor_frame_deframer_crc_top");
    $finish;
  end

endmodule
